// File: hw/rtl/sfsc_pkg.sv
package sfsc_pkg;

    // Wheel geometry: one revolution is 2**POS_W steps, positions wrap by masking.
    localparam int POS_W       = 11;
    localparam int CMD_W       = 3;
    localparam int MODE_W      = 3;
    localparam int STEPS_W     = 13;
    localparam int PERIOD_W    = 20;
    localparam int HOLD_W      = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF    = 3'd0,
        MODE_PAST   = 3'd1,
        MODE_TO     = 3'd2,
        MODE_OFFSET = 3'd3,
        MODE_RUN    = 3'd4,
        MODE_PAUSE  = 3'd5
    } t_mode;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 3'd0,
        CMD_HOME  = 3'd1,
        CMD_START = 3'd2,
        CMD_STEP  = 3'd3,
        CMD_PAUSE = 3'd4,
        CMD_LOOP  = 3'd5
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_OFFSET   = 3'd0,
        CFG_DEBOUNCE_TIME  = 3'd1,
        CFG_PAUSE_HOLD     = 3'd2,
        CFG_HOMING_PERIOD  = 3'd3,
        CFG_LOOP_REV_OFS   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [POS_W-1:0]    start_offset;
        logic [PERIOD_W-1:0] debounce_time;
        logic [HOLD_W-1:0]   pause_hold_time;
        logic [PERIOD_W-1:0] homing_step_period;
        logic [POS_W-1:0]    resync_offset;
    } t_cfg;

    localparam logic [PERIOD_W-1:0] DEBOUNCE_TIME_RST  = 20'd5000;
    localparam logic [HOLD_W-1:0]   PAUSE_HOLD_RST     = 24'd1000000;
    localparam logic [PERIOD_W-1:0] HOMING_PERIOD_RST  = 20'd2000;

endpackage

// File: hw/rtl/sfsc_debounce.sv
module sfsc_debounce #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_advance,
    input  logic [sfsc_pkg::CMD_W-1:0]      i_cmd,
    input  logic                            i_raw,
    input  logic [TIME_WIDTH-1:0]           i_time_tick,
    input  logic [sfsc_pkg::PERIOD_W-1:0]   i_debounce_time,
    output logic                            o_button
);

    logic                  r_stable, n_stable;
    logic                  r_active, n_active;
    logic [TIME_WIDTH-1:0] r_start,  n_start;

    logic [TIME_WIDTH+sfsc_pkg::PERIOD_W-1:0] w_sum;
    logic [TIME_WIDTH-1:0]                    w_deadline;

    // Deadline wraps modulo the time width.
    assign w_sum      = {{sfsc_pkg::PERIOD_W{1'b0}}, r_start}
                      + {{TIME_WIDTH{1'b0}}, i_debounce_time};
    assign w_deadline = w_sum[TIME_WIDTH-1:0];

    always_comb begin
        n_stable = r_stable;
        n_active = r_active;
        n_start  = r_start;
        if (i_cmd == sfsc_pkg::CMD_TICK) begin
            if (r_stable != i_raw) begin
                if (r_active && (w_deadline <= i_time_tick)) begin
                    n_stable = i_raw;
                    n_active = 1'b0;
                end else if (!r_active) begin
                    n_start  = i_time_tick;
                    n_active = 1'b1;
                end
            end
        end else if (i_cmd == sfsc_pkg::CMD_HOME) begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b0;
            r_active <= 1'b0;
            r_start  <= '0;
        end else if (i_advance) begin
            r_stable <= n_stable;
            r_active <= n_active;
            r_start  <= n_start;
        end
    end

    assign o_button = n_stable;

endmodule

// File: hw/rtl/sfsc_motion.sv
module sfsc_motion #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_advance,
    input  logic [sfsc_pkg::CMD_W-1:0]      i_cmd,
    input  logic [sfsc_pkg::STEPS_W-1:0]    i_step_count,
    input  logic [sfsc_pkg::PERIOD_W-1:0]   i_run_period,
    input  logic [TIME_WIDTH-1:0]           i_time,
    input  logic [TIME_WIDTH-1:0]           i_time_tick,
    input  logic                            i_button,
    input  sfsc_pkg::t_cfg                  i_cfg,
    output logic [sfsc_pkg::MODE_W-1:0]     o_mode,
    output logic                            o_phase,
    output logic [sfsc_pkg::POS_W-1:0]      o_position
);

    typedef struct packed {
        sfsc_pkg::t_mode                mode;
        logic                           phase;
        logic [sfsc_pkg::POS_W-1:0]     pos;
        logic [sfsc_pkg::POS_W-1:0]     tgt;
        logic                           tv;
        logic                           la;
        logic [TIME_WIDTH-1:0]          nst;
        logic [TIME_WIDTH-1:0]          ps;
    } t_motion;

    t_motion r_st, n_st;
    logic    r_prev, n_prev;

    t_motion w_s1, w_s2, w_run;

    logic [TIME_WIDTH+sfsc_pkg::PERIOD_W-1:0] w_run_ext, w_home_ext;
    logic [TIME_WIDTH-1:0]                    w_run_per, w_home_per;
    logic [TIME_WIDTH+sfsc_pkg::HOLD_W-1:0]   w_hold_sum;
    logic [sfsc_pkg::POS_W-1:0]               w_tgt;
    logic                                     w_idle;

    // One step decision at time t: arrival check, optional extra loop, step when due.
    function automatic t_motion step_on_time(
        input t_motion               s,
        input logic [TIME_WIDTH-1:0] t,
        input logic [TIME_WIDTH-1:0] run_per,
        input logic [TIME_WIDTH-1:0] home_per
    );
        t_motion r;
        logic    check;
        logic    due;
        r     = s;
        check = 1'b1;
        due   = (t >= s.nst);
        if (s.mode != sfsc_pkg::MODE_PAUSE && s.mode != sfsc_pkg::MODE_OFF) begin
            if (s.tv && (s.pos == s.tgt)) begin
                check = 1'b0;
                if (s.la) begin
                    if (due) begin
                        r.la  = 1'b0;
                        check = 1'b1;
                    end
                end else begin
                    r.mode = sfsc_pkg::MODE_PAUSE;
                    r.tv   = 1'b0;
                    r.ps   = t;
                end
            end
            if (check && due) begin
                r.phase = ~s.phase;
                r.pos   = s.pos + sfsc_pkg::POS_W'(1);
                r.nst   = t + ((s.mode == sfsc_pkg::MODE_RUN) ? run_per : home_per);
            end
        end
        return r;
    endfunction

    // Step periods reduced modulo the time width.
    assign w_run_ext  = {{TIME_WIDTH{1'b0}}, i_run_period};
    assign w_home_ext = {{TIME_WIDTH{1'b0}}, i_cfg.homing_step_period};
    assign w_run_per  = w_run_ext[TIME_WIDTH-1:0];
    assign w_home_per = w_home_ext[TIME_WIDTH-1:0];

    assign w_tgt  = r_st.pos + i_step_count[sfsc_pkg::POS_W-1:0];
    assign w_idle = (r_st.mode == sfsc_pkg::MODE_PAUSE) || (r_st.mode == sfsc_pkg::MODE_OFF);

    // Tick path: first step check, then the per-mode action.
    always_comb begin
        w_s1       = step_on_time(r_st, i_time_tick, w_run_per, w_home_per);
        w_s2       = w_s1;
        w_run      = w_s1;
        w_hold_sum = {{sfsc_pkg::HOLD_W{1'b0}}, w_s1.ps}
                   + {{TIME_WIDTH{1'b0}}, i_cfg.pause_hold_time};
        unique case (w_s1.mode)
            sfsc_pkg::MODE_PAST: begin
                if (i_button) begin
                    w_s2 = step_on_time(w_s1, i_time_tick, w_run_per, w_home_per);
                end else begin
                    w_s2.mode = sfsc_pkg::MODE_TO;
                end
            end
            sfsc_pkg::MODE_TO: begin
                if (!i_button) begin
                    w_s2 = step_on_time(w_s1, i_time_tick, w_run_per, w_home_per);
                end else begin
                    w_s2.mode = sfsc_pkg::MODE_OFFSET;
                    w_s2.pos  = '0;
                    w_s2.tgt  = i_cfg.start_offset;
                    w_s2.tv   = 1'b1;
                end
            end
            sfsc_pkg::MODE_OFFSET: begin
                w_s2 = step_on_time(w_s1, i_time_tick, w_run_per, w_home_per);
                if (w_s2.mode == sfsc_pkg::MODE_PAUSE) begin
                    w_s2.pos = '0;
                end
            end
            sfsc_pkg::MODE_RUN: begin
                // rising switch edge: wheel is back at home
                if (i_button && !r_prev) begin
                    w_run.pos = i_cfg.resync_offset - i_cfg.start_offset;
                end
                w_s2 = step_on_time(w_run, i_time_tick, w_run_per, w_home_per);
            end
            sfsc_pkg::MODE_PAUSE: begin
                if (i_time_tick >= w_hold_sum[TIME_WIDTH-1:0]) begin
                    w_s2.mode = sfsc_pkg::MODE_OFF;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_st   = r_st;
        n_prev = r_prev;
        unique case (i_cmd)
            sfsc_pkg::CMD_TICK: begin
                n_st   = w_s2;
                n_prev = i_button;
            end
            sfsc_pkg::CMD_HOME: begin
                n_st.mode = i_button ? sfsc_pkg::MODE_PAST : sfsc_pkg::MODE_TO;
                n_st.nst  = '0;
            end
            sfsc_pkg::CMD_START: begin
                if (w_idle) begin
                    n_st.mode = sfsc_pkg::MODE_RUN;
                    n_st.nst  = '0;
                    n_st.tgt  = w_tgt;
                    n_st.tv   = 1'b1;
                end
            end
            sfsc_pkg::CMD_STEP: begin
                if (w_idle) begin
                    n_st.mode = sfsc_pkg::MODE_RUN;
                end
                n_st.tgt = w_tgt;
                n_st.tv  = 1'b1;
            end
            sfsc_pkg::CMD_PAUSE: begin
                n_st.mode = sfsc_pkg::MODE_PAUSE;
                n_st.tv   = 1'b0;
                n_st.ps   = i_time;
            end
            sfsc_pkg::CMD_LOOP: begin
                n_st.la = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode  <= sfsc_pkg::MODE_OFF;
            r_st.phase <= 1'b0;
            r_st.pos   <= '0;
            r_st.tgt   <= '0;
            r_st.tv    <= 1'b0;
            r_st.la    <= 1'b0;
            r_st.nst   <= '0;
            r_st.ps    <= '0;
            r_prev     <= 1'b0;
        end else if (i_advance) begin
            r_st   <= n_st;
            r_prev <= n_prev;
        end
    end

    assign o_mode     = n_st.mode;
    assign o_phase    = n_st.phase;
    assign o_position = n_st.pos;

endmodule

// File: hw/rtl/split_flap_stepper_controller.sv
// Channel  | Signals                              | Item contents (lowest bit first)
// ---------+--------------------------------------+-----------------------------------------
// in       | s_axis_tvalid/tready/tdata/tuser     | tuser: cmd[2:0]; tdata: raw_button[0],
//          |                                      |   step_count[13:1], run_step_period[33:14]
// out      | m_axis_tvalid/tready/tdata           | tdata: mode[2:0], step_pin[3],
//          |                                      |   position[14:4], button[15]
// config   | i_cfg_we/i_cfg_idx/i_cfg_wdata       | one register per write, no read-back
//
// Flow: one item per clock sustained while results are taken; an accepted item
//   is held in the input register and its result is then loaded into the result
//   register, where it stays valid until taken.
// All per-item work is one pass of compare/add logic over the motion state, set
//   by the two chained step checks of a tick.
// Reset: synchronous, active low; valid flags, time, debounce and motion state cleared, registers back to defaults.
// Stalls: when the result register is full and not taken, the item in the input
//   register waits and the input side is backpressured; a taken result frees
//   both stages in the same cycle.
module split_flap_stepper_controller #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input items
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // raw_button[0], step_count[13:1], run_step_period[33:14], zero pad
    input  logic [sfsc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // cmd[2:0]
    input  logic [sfsc_pkg::CMD_W-1:0]           s_axis_tuser,
    // result items
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // mode[2:0], step_pin[3], position[14:4], button[15]
    output logic [sfsc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [sfsc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sfsc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    // Input register
    logic                              r_in_valid;
    logic [sfsc_pkg::CMD_W-1:0]        r_in_cmd;
    logic                              r_in_raw;
    logic [sfsc_pkg::STEPS_W-1:0]      r_in_steps;
    logic [sfsc_pkg::PERIOD_W-1:0]     r_in_period;

    // Result register
    logic                              r_out_valid;
    logic [sfsc_pkg::OUT_TDATA_W-1:0]  r_out_data;

    // Time count, advanced once per tick item
    logic [TIME_WIDTH-1:0]             r_time;
    logic [TIME_WIDTH-1:0]             w_time_tick;

    sfsc_pkg::t_cfg                    r_cfg;

    logic                              w_advance;
    logic                              w_button;
    logic [sfsc_pkg::MODE_W-1:0]       w_mode;
    logic                              w_phase;
    logic [sfsc_pkg::POS_W-1:0]        w_position;

    // The held item is processed whenever the result register can take its result.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_time_tick   = r_time + TIME_WIDTH'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd    <= s_axis_tuser;
            r_in_raw    <= s_axis_tdata[0];
            r_in_steps  <= s_axis_tdata[13:1];
            r_in_period <= s_axis_tdata[33:14];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else if (w_advance && (r_in_cmd == sfsc_pkg::CMD_TICK)) begin
            r_time <= w_time_tick;
        end
    end

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_offset        <= '0;
            r_cfg.debounce_time       <= sfsc_pkg::DEBOUNCE_TIME_RST;
            r_cfg.pause_hold_time     <= sfsc_pkg::PAUSE_HOLD_RST;
            r_cfg.homing_step_period  <= sfsc_pkg::HOMING_PERIOD_RST;
            r_cfg.resync_offset       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sfsc_pkg::CFG_START_OFFSET:
                    r_cfg.start_offset <= i_cfg_wdata[sfsc_pkg::POS_W-1:0];
                sfsc_pkg::CFG_DEBOUNCE_TIME:
                    r_cfg.debounce_time <= i_cfg_wdata[sfsc_pkg::PERIOD_W-1:0];
                sfsc_pkg::CFG_PAUSE_HOLD:
                    r_cfg.pause_hold_time <= i_cfg_wdata[sfsc_pkg::HOLD_W-1:0];
                sfsc_pkg::CFG_HOMING_PERIOD:
                    r_cfg.homing_step_period <= i_cfg_wdata[sfsc_pkg::PERIOD_W-1:0];
                sfsc_pkg::CFG_LOOP_REV_OFS:
                    r_cfg.resync_offset <= i_cfg_wdata[sfsc_pkg::POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Switch debounce runs first on a tick; the mode machine sees its new level.
    sfsc_debounce #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_debounce (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (w_advance),
        .i_cmd           (r_in_cmd),
        .i_raw           (r_in_raw),
        .i_time_tick     (w_time_tick),
        .i_debounce_time (r_cfg.debounce_time),
        .o_button        (w_button)
    );

    sfsc_motion #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_motion (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_cmd        (r_in_cmd),
        .i_step_count (r_in_steps),
        .i_run_period (r_in_period),
        .i_time       (r_time),
        .i_time_tick  (w_time_tick),
        .i_button     (w_button),
        .i_cfg        (r_cfg),
        .o_mode       (w_mode),
        .o_phase      (w_phase),
        .o_position   (w_position)
    );

    // Result register: holds the state after the item until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {w_button, w_position, w_phase, w_mode};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// File: sim/tb_split_flap_stepper_controller.sv
`timescale 1ns / 1ps

module tb_split_flap_stepper_controller;
    import sfsc_pkg::*;

    // cmd codes with no meaning in the block; they must leave the state alone
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int MAX_WAIT        = 18;
    localparam int DRAIN_LIMIT     = 5000;

    // Status word as it sits in m_axis_tdata, lowest field last in the list.
    typedef struct packed {
        logic             button;
        logic [POS_W-1:0] position;
        logic             step_pin;
        t_mode            mode;
    } t_status;

    // One row of the directed table. When typed is set, the status is taken
    // from the row instead of the predictor.
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic                raw;
        logic [STEPS_W-1:0]  steps;
        logic [PERIOD_W-1:0] period;
        logic                typed;
        t_status             status;
    } t_row;

    localparam int DIR_ROWS = 23;
    localparam t_row DIRECTED [0:DIR_ROWS-1] = '{
        // spare codes straight out of reset: nothing moves
        '{CMD_SPARE6, 1'b0, 13'd0,      20'd0,       1'b1, '{1'b0, 11'd0, 1'b0, MODE_OFF}},
        '{CMD_SPARE7, 1'b1, 13'h1FFF,   20'hFFFFF,   1'b1, '{1'b0, 11'd0, 1'b0, MODE_OFF}},
        // raw switch goes high; debounce starts, button stays low
        '{CMD_TICK,   1'b1, 13'd0,      20'd0,       1'b1, '{1'b0, 11'd0, 1'b0, MODE_OFF}},
        '{CMD_LOOP,   1'b0, 13'd0,      20'd0,       1'b1, '{1'b0, 11'd0, 1'b0, MODE_OFF}},
        // largest step count wraps the target to 2047
        '{CMD_START,  1'b0, 13'h1FFF,   20'd0,       1'b1, '{1'b0, 11'd0, 1'b0, MODE_RUN}},
        // zero period: both step checks of the tick fire
        '{CMD_TICK,   1'b0, 13'd0,      20'd0,       1'b1, '{1'b0, 11'd2, 1'b0, MODE_RUN}},
        // target onto current position with loop armed -> one extra revolution
        '{CMD_STEP,   1'b0, 13'd0,      20'd0,       1'b0, '0},
        '{CMD_TICK,   1'b0, 13'd0,      20'd0,       1'b0, '0},
        '{CMD_TICK,   1'b1, 13'd0,      20'hFFFFF,   1'b0, '0},
        '{CMD_TICK,   1'b1, 13'h0AAA,   20'h55555,   1'b0, '0},
        // start while running is dropped
        '{CMD_START,  1'b0, 13'd5,      20'd0,       1'b0, '0},
        '{CMD_PAUSE,  1'b0, 13'd0,      20'd0,       1'b0, '0},
        '{CMD_TICK,   1'b0, 13'h1555,   20'hAAAAA,   1'b0, '0},
        // home with button low goes straight to homing-to
        '{CMD_HOME,   1'b0, 13'd0,      20'd0,       1'b0, '0},
        '{CMD_START,  1'b0, 13'd7,      20'd0,       1'b0, '0},
        // step during homing leaves a stale target behind
        '{CMD_STEP,   1'b0, 13'h1555,   20'd0,       1'b0, '0},
        '{CMD_TICK,   1'b1, 13'h0AAA,   20'h55555,   1'b0, '0},
        '{CMD_TICK,   1'b1, 13'h1555,   20'hAAAAA,   1'b0, '0},
        '{CMD_SPARE6, 1'b1, 13'h1FFF,   20'hFFFFF,   1'b0, '0},
        '{CMD_PAUSE,  1'b0, 13'd0,      20'd0,       1'b0, '0},
        '{CMD_TICK,   1'b0, 13'd0,      20'd0,       1'b0, '0},
        '{CMD_START,  1'b0, 13'h1000,   20'd0,       1'b0, '0},
        '{CMD_TICK,   1'b0, 13'd0,      20'd0,       1'b0, '0}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // raw_button, step_count, run_step_period
    logic [CMD_W-1:0]       s_axis_tuser;   // cmd
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // mode, step_pin, position, button
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;

    split_flap_stepper_controller uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Controller model: motion state, debounce and the mode machine.
    // ------------------------------------------------------------------
    t_mode               mode_q;
    logic                phase_q;
    logic [POS_W-1:0]    wheel_pos;
    logic [POS_W-1:0]    target_pos;
    logic                target_set;
    logic                loop_armed;
    logic                btn_stable;
    logic                btn_prev;
    logic                db_running;
    logic [31:0]         db_start;
    logic [31:0]         next_step_at;
    logic [31:0]         pause_at;
    logic [31:0]         now_ticks;
    logic [PERIOD_W-1:0] run_period;

    logic [POS_W-1:0]    cfg_start_ofs;
    logic [PERIOD_W-1:0] cfg_debounce;
    logic [HOLD_W-1:0]   cfg_hold;
    logic [PERIOD_W-1:0] cfg_home_period;
    logic [POS_W-1:0]    cfg_loop_ofs;

    t_status status_q[$];

    int  items_sent;
    int  results_seen;
    int  fail_count;
    int  loop_resets;
    int  settings_used;
    int  mode_seen [0:7];
    logic tx_calm;
    logic rx_calm;

    function automatic void aim_at(input logic [STEPS_W-1:0] n);
        target_pos = wheel_pos + n[POS_W-1:0];
        target_set = 1'b1;
    endfunction

    function automatic void enter_pause();
        mode_q     = MODE_PAUSE;
        target_set = 1'b0;
        pause_at   = now_ticks;
    endfunction

    // One step check: stop at the target (or burn the armed loop), else step
    // when the step time has come.
    function automatic void try_step();
        logic go;
        go = 1'b1;
        if (mode_q == MODE_PAUSE || mode_q == MODE_OFF)
            return;
        if (target_set && wheel_pos == target_pos) begin
            go = 1'b0;
            if (loop_armed) begin
                if (now_ticks >= next_step_at) begin
                    loop_armed = 1'b0;
                    go         = 1'b1;
                end
            end else begin
                enter_pause();
            end
        end
        if (go && now_ticks >= next_step_at) begin
            phase_q   = ~phase_q;
            wheel_pos = wheel_pos + 1'b1;
            if (mode_q == MODE_RUN)
                next_step_at = now_ticks + 32'(run_period);
            else
                next_step_at = now_ticks + 32'(cfg_home_period);
        end
    endfunction

    task automatic advance_controller(input logic [CMD_W-1:0] cmd, input logic raw,
                                      input logic [STEPS_W-1:0] steps,
                                      input logic [PERIOD_W-1:0] period,
                                      output t_status st);
        logic want_btn;
        run_period = period;
        case (cmd)
            CMD_TICK: begin
                now_ticks = now_ticks + 32'd1;
                // timer keeps running if raw drops back to the stable level
                if (btn_stable != raw) begin
                    if (db_running && (db_start + 32'(cfg_debounce)) <= now_ticks) begin
                        btn_stable = raw;
                        db_running = 1'b0;
                    end else if (!db_running) begin
                        db_start   = now_ticks;
                        db_running = 1'b1;
                    end
                end
                try_step();
                case (mode_q)
                    MODE_PAST, MODE_TO: begin
                        want_btn = (mode_q == MODE_TO);
                        if (btn_stable != want_btn) begin
                            try_step();
                        end else if (mode_q == MODE_PAST) begin
                            mode_q = MODE_TO;
                        end else begin
                            mode_q    = MODE_OFFSET;
                            wheel_pos = '0;
                            aim_at(STEPS_W'(cfg_start_ofs));
                        end
                    end
                    MODE_OFFSET: begin
                        try_step();
                        if (mode_q == MODE_PAUSE)
                            wheel_pos = '0;
                    end
                    MODE_RUN: begin
                        // switch rising edge: wheel passed home, re-sync position
                        if (btn_stable && !btn_prev) begin
                            wheel_pos = cfg_loop_ofs - cfg_start_ofs;
                            loop_resets++;
                        end
                        try_step();
                    end
                    MODE_PAUSE: begin
                        if (now_ticks >= pause_at + 32'(cfg_hold))
                            mode_q = MODE_OFF;
                    end
                    default: ;
                endcase
                btn_prev = btn_stable;
            end
            CMD_HOME: begin
                db_running   = 1'b0;
                mode_q       = btn_stable ? MODE_PAST : MODE_TO;
                next_step_at = '0;
            end
            CMD_START: begin
                if (mode_q == MODE_PAUSE || mode_q == MODE_OFF) begin
                    mode_q       = MODE_RUN;
                    next_step_at = '0;
                    aim_at(steps);
                end
            end
            CMD_STEP: begin
                if (mode_q == MODE_PAUSE || mode_q == MODE_OFF)
                    mode_q = MODE_RUN;
                aim_at(steps);
            end
            CMD_PAUSE: enter_pause();
            CMD_LOOP:  loop_armed = 1'b1;
            default: ;
        endcase
        st.mode     = mode_q;
        st.step_pin = phase_q;
        st.position = wheel_pos;
        st.button   = btn_stable;
    endtask

    // Per-item random wait up to MAX_WAIT, with runs of back-to-back items mixed in.
    function automatic int draw_wait(inout logic calm);
        if ($urandom_range(0, 15) == 0)
            calm = ~calm;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // ------------------------------------------------------------------
    // Input side: drive at falling edge, item taken at rising edge.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic raw,
                             input logic [STEPS_W-1:0] steps,
                             input logic [PERIOD_W-1:0] period,
                             input logic typed, input t_status typed_status);
        int      gap;
        t_status predicted;
        @(negedge i_clk);
        gap = draw_wait(tx_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-34){1'b0}}, period, steps, raw};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        advance_controller(cmd, raw, steps, period, predicted);
        status_q.push_back(typed ? typed_status : predicted);
        items_sent++;
    endtask

    task automatic cfg_put(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_START_OFFSET:  cfg_start_ofs   = val[POS_W-1:0];
            CFG_DEBOUNCE_TIME: cfg_debounce    = val[PERIOD_W-1:0];
            CFG_PAUSE_HOLD:    cfg_hold        = val[HOLD_W-1:0];
            CFG_HOMING_PERIOD: cfg_home_period = val[PERIOD_W-1:0];
            CFG_LOOP_REV_OFS:  cfg_loop_ofs    = val[POS_W-1:0];
            default: ;
        endcase
    endtask

    // Input side goes quiet, then every pending status has to come back.
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        // two-stage pipe: keep clocking after the drain so both stages empty
        repeat (6) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, compare at rising edge.
    // ------------------------------------------------------------------
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        rx_calm       = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = draw_wait(rx_calm);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && m_axis_tvalid && m_axis_tready));
        end
    end

    t_status got_status;
    t_status exp_status;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_status = t_status'(m_axis_tdata);
            results_seen++;
            if (status_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: status item with nothing pending: %h", $realtime,
                             m_axis_tdata);
            end else begin
                exp_status = status_q.pop_front();
                mode_seen[exp_status.mode]++;
                if (got_status.mode     !== exp_status.mode     ||
                    got_status.step_pin !== exp_status.step_pin ||
                    got_status.position !== exp_status.position ||
                    got_status.button   !== exp_status.button) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"%0t: status mismatch: mode %0d/%0d step_pin %0d/%0d ",
                                  "position %0d/%0d button %0d/%0d (expected/actual)"},
                                 $realtime, exp_status.mode, got_status.mode,
                                 exp_status.step_pin, got_status.step_pin,
                                 exp_status.position, got_status.position,
                                 exp_status.button, got_status.button);
                end
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [CMD_W-1:0]    cmd;
        logic [STEPS_W-1:0]  steps;
        logic [PERIOD_W-1:0] period;
        logic                raw;
        logic                switch_level;
        logic                follow_wheel;
        int                  pick;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        tx_calm       = 1'b0;
        items_sent    = 0;
        results_seen  = 0;
        fail_count    = 0;
        loop_resets   = 0;
        settings_used = 1;
        foreach (mode_seen[k]) mode_seen[k] = 0;

        // model back to its reset state, registers at their defaults
        mode_q          = MODE_OFF;
        phase_q         = 1'b0;
        wheel_pos       = '0;
        target_pos      = '0;
        target_set      = 1'b0;
        loop_armed      = 1'b0;
        btn_stable      = 1'b0;
        btn_prev        = 1'b0;
        db_running      = 1'b0;
        db_start        = '0;
        next_step_at    = '0;
        pause_at        = '0;
        now_ticks       = '0;
        run_period      = '0;
        cfg_start_ofs   = '0;
        cfg_debounce    = DEBOUNCE_TIME_RST;
        cfg_hold        = PAUSE_HOLD_RST;
        cfg_home_period = HOMING_PERIOD_RST;
        cfg_loop_ofs    = '0;

        // reset held low, then released at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, default registers
        for (int r = 0; r < DIR_ROWS; r++)
            send_item(DIRECTED[r].cmd, DIRECTED[r].raw, DIRECTED[r].steps,
                      DIRECTED[r].period, DIRECTED[r].typed, DIRECTED[r].status);
        settle();

        // random part: one register setting per phase
        switch_level = 1'b0;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin   // everything at its low end, homing period at 1
                    cfg_put(CFG_START_OFFSET,  '0);
                    cfg_put(CFG_DEBOUNCE_TIME, '0);
                    cfg_put(CFG_PAUSE_HOLD,    '0);
                    cfg_put(CFG_HOMING_PERIOD, 24'd1);
                    cfg_put(CFG_LOOP_REV_OFS,  '0);
                end
                1: begin   // everything at its high end
                    cfg_put(CFG_START_OFFSET,  24'd2047);
                    cfg_put(CFG_DEBOUNCE_TIME, 24'hFFFFF);
                    cfg_put(CFG_PAUSE_HOLD,    24'hFFFFFF);
                    cfg_put(CFG_HOMING_PERIOD, 24'hFFFFF);
                    cfg_put(CFG_LOOP_REV_OFS,  24'd2047);
                end
                default: begin   // small timings so the machine gets around
                    cfg_put(CFG_START_OFFSET, CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
                            $urandom_range(0, 2047) : $urandom_range(0, 40)));
                    cfg_put(CFG_DEBOUNCE_TIME, CFG_DATA_W'($urandom_range(0, 6)));
                    cfg_put(CFG_PAUSE_HOLD,    CFG_DATA_W'($urandom_range(0, 40)));
                    cfg_put(CFG_HOMING_PERIOD, CFG_DATA_W'($urandom_range(1, 4)));
                    cfg_put(CFG_LOOP_REV_OFS,  CFG_DATA_W'($urandom_range(0, 2047)));
                end
            endcase
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            settings_used++;
            // even phases: the switch follows the wheel, high near the start of every 32 positions
            follow_wheel = (ph % 2 == 0);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if      (pick < 78) cmd = CMD_TICK;
                else if (pick < 80) cmd = CMD_HOME;
                else if (pick < 87) cmd = CMD_START;
                else if (pick < 90) cmd = CMD_STEP;
                else if (pick < 92) cmd = CMD_PAUSE;
                else if (pick < 97) cmd = CMD_LOOP;
                else                cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;

                steps  = STEPS_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                              : $urandom_range(0, 48));
                period = PERIOD_W'(($urandom_range(0, 24) == 0) ?
                                   $urandom_range(0, 20'hFFFFF) : $urandom_range(0, 3));

                if (follow_wheel) begin
                    switch_level = (wheel_pos[4:0] < 5'd6);
                end else if ($urandom_range(0, 11) == 0) begin
                    switch_level = ~switch_level;
                end
                // occasional one-item glitch on the raw switch
                raw = switch_level ^ ($urandom_range(0, 39) == 0);

                send_item(cmd, raw, steps, period, 1'b0, '0);
            end
            settle();
        end

        repeat (10) @(posedge i_clk);
        if (status_q.size() != 0) begin
            fail_count += status_q.size();
            $display("%0d status items never came back", status_q.size());
        end

        $display("Run: %0d items under %0d register settings, %0d status items compared",
                 items_sent, settings_used, results_seen);
        $display({"Status by mode: off %0d, homing %0d/%0d/%0d, running %0d, ",
                  "paused %0d; home re-syncs %0d"},
                 mode_seen[MODE_OFF], mode_seen[MODE_PAST], mode_seen[MODE_TO],
                 mode_seen[MODE_OFFSET], mode_seen[MODE_RUN], mode_seen[MODE_PAUSE],
                 loop_resets);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/sfsc_pkg.sv
hw/rtl/sfsc_debounce.sv
hw/rtl/sfsc_motion.sv
hw/rtl/split_flap_stepper_controller.sv
sim/tb_split_flap_stepper_controller.sv
